>>> rtl/core/bta_pkg.sv
// Shared types, constants and shading functions for the bitmap to ASCII shader.
// No dependencies; every other file in rtl/core uses this package.
`default_nettype none

package bta_pkg;

   // Largest source bitmap the pixel store can hold
   localparam int MAX_SRC_WIDTH  = 64;
   localparam int MAX_SRC_HEIGHT = 64;

   localparam int MAX_DIM = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
   localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

   // Widths of the fixed register and payload fields
   localparam int SRC_CSR_W = 7;
   localparam int DST_CSR_W = 8;
   localparam int POS_W     = 8;
   localparam int CHAN_W    = 8;
   localparam int GLYPH_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   // Derived widths
   localparam int SZ_W   = ($clog2(MAX_DIM + 1) > SRC_CSR_W) ? $clog2(MAX_DIM + 1) : SRC_CSR_W;
   localparam int PROD_W = POS_W + SZ_W;
   localparam int QW     = ($clog2(MAX_DIM) > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W  = $clog2(QW + 1);
   localparam int XW     = ($clog2(MAX_SRC_WIDTH) > 1) ? $clog2(MAX_SRC_WIDTH) : 1;
   localparam int YW     = ($clog2(MAX_SRC_HEIGHT) > 1) ? $clog2(MAX_SRC_HEIGHT) : 1;
   localparam int ADDR_W = ($clog2(STORE_DEPTH) > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SUM_W  = CHAN_W + 2;
   localparam int SCALED_W = SUM_W + 4;

   // Reset values of the size registers
   localparam logic [SRC_CSR_W-1:0] SRC_WIDTH_RST  = 7'd64;
   localparam logic [SRC_CSR_W-1:0] SRC_HEIGHT_RST = 7'd64;
   localparam logic [DST_CSR_W-1:0] DST_WIDTH_RST  = 8'd80;
   localparam logic [DST_CSR_W-1:0] DST_HEIGHT_RST = 8'd24;

   localparam logic [GLYPH_W-1:0] SPACE_CODE = 7'h20;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD_X,
      ST_DIV_X,
      ST_LOAD_Y,
      ST_DIV_Y,
      ST_READ,
      ST_SHADE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              see_through;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Saturate a source size register to 1..lim
   function automatic logic [SZ_W-1:0] clamp_size(logic [SRC_CSR_W-1:0] v,
                                                  logic [SZ_W-1:0] lim);
      logic [SZ_W-1:0] ext;
      ext = SZ_W'(v);
      if (ext == '0) begin
         return SZ_W'(1);
      end else if (ext > lim) begin
         return lim;
      end
      return ext;
   endfunction

   // Map an opaque pixel's channel sum onto the ten-step brightness ramp " .:-=+*#%@"
   function automatic logic [GLYPH_W-1:0] shade_glyph(logic [SUM_W-1:0] sum);
      logic [SCALED_W-1:0] scaled;
      logic [3:0]          idx;
      logic [GLYPH_W-1:0]  code;
      scaled = SCALED_W'(sum) * SCALED_W'(10);
      idx = 4'd0;
      // count the ramp thresholds the scaled sum reaches
      for (int k = 1; k <= 9; k++) begin
         if (scaled >= SCALED_W'(768 * k)) begin
            idx = idx + 4'd1;
         end
      end
      unique case (idx)
         4'd0:    code = 7'h20;
         4'd1:    code = 7'h2E;
         4'd2:    code = 7'h3A;
         4'd3:    code = 7'h2D;
         4'd4:    code = 7'h3D;
         4'd5:    code = 7'h2B;
         4'd6:    code = 7'h2A;
         4'd7:    code = 7'h23;
         4'd8:    code = 7'h25;
         4'd9:    code = 7'h40;
         default: code = 7'h20;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/bta_div.sv
// Restoring divider, one quotient bit per cycle, shared by both scaling divisions.
// Depends on bta_pkg for widths and the control and status structs.
`default_nettype none

module bta_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bta_pkg::div_ctl_type           ctl,
   input  wire logic [bta_pkg::PROD_W-1:0]     dividend,
   input  wire logic [bta_pkg::DST_CSR_W-1:0]  divisor,
   output bta_pkg::div_stat_type               stat,
   output logic [bta_pkg::QW-1:0]              quotient
);

   logic                            run_ff, run_in;
   logic [bta_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [bta_pkg::DST_CSR_W-1:0]   rem_ff, rem_in;
   logic [bta_pkg::DST_CSR_W-1:0]   dvs_ff, dvs_in;
   logic [bta_pkg::QW-1:0]          low_ff, low_in;
   logic [bta_pkg::QW-1:0]          quo_ff, quo_in;
   logic [bta_pkg::DST_CSR_W:0]     trial;
   logic [bta_pkg::DST_CSR_W:0]     diff;
   logic                            ge;
   logic                            done;

   // the quotient is known to fit QW bits, so the dividend bits above QW
   // form a partial remainder that is already below the divisor
   assign trial = {rem_ff, low_ff[bta_pkg::QW-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});
   assign done  = run_ff && (cnt_ff == '0);

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = bta_pkg::CNT_W'(bta_pkg::QW);
         rem_in = dividend[bta_pkg::QW +: bta_pkg::DST_CSR_W];
         low_in = dividend[bta_pkg::QW-1:0];
         dvs_in = divisor;
         quo_in = '0;
      end else if (done) begin
         run_in = 1'b0;
      end else if (run_ff) begin
         cnt_in = cnt_ff - bta_pkg::CNT_W'(1);
         rem_in = ge ? diff[bta_pkg::DST_CSR_W-1:0] : trial[bta_pkg::DST_CSR_W-1:0];
         low_in = low_ff << 1;
         quo_in = (quo_ff << 1) | bta_pkg::QW'(ge);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done;
   assign quotient  = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/bta_store.sv
// Source pixel store: one write port, one registered read port.
// Depends on bta_pkg for the pixel type and store geometry.
`default_nettype none

module bta_store (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [bta_pkg::ADDR_W-1:0]   wr_addr,
   input  wire bta_pkg::pixel_type           wr_data,
   input  wire logic                         rd_en,
   input  wire logic [bta_pkg::ADDR_W-1:0]   rd_addr,
   output bta_pkg::pixel_type                rd_data
);

   bta_pkg::pixel_type mem [bta_pkg::STORE_DEPTH];
   bta_pkg::pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/bitmap_to_ascii_shader_unit.sv
// Top level of the bitmap to ASCII shader: size registers, sequencer, shared
// multiplier and divider, pixel store. Depends on bta_pkg, bta_div, bta_store.
//
//   channel | ports                     | direction | moves
//   req     | req_valid / req_ready     | in        | pixel write or cell render request
//   rsp     | rsp_valid / rsp_ready     | out       | glyph and out-of-range flag
//   csr     | csr_wen, csr_index        | in        | size register write, no read-back
//
// A pixel write gives no response.
// A render in range steps through LOAD_X, DIV_X, LOAD_Y, DIV_Y, READ, SHADE and
// DONE: each scaling division runs on the shared divider, the rest is multiply,
// store read, shading and handoff. A render outside the grid goes straight to DONE.
// req_ready is low while a render is in flight; a finished response waits in
// the output register, and a later render stalls only at its own handoff.
// Reset (synchronous) restores the size registers; the pixel store is not cleared.
`default_nettype none

module bitmap_to_ascii_shader_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_opcode,
   input  wire logic [bta_pkg::POS_W-1:0]       req_pos_x,
   input  wire logic [bta_pkg::POS_W-1:0]       req_pos_y,
   input  wire logic                            req_see_through,
   input  wire logic [bta_pkg::CHAN_W-1:0]      req_red,
   input  wire logic [bta_pkg::CHAN_W-1:0]      req_green,
   input  wire logic [bta_pkg::CHAN_W-1:0]      req_blue,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [bta_pkg::GLYPH_W-1:0]          rsp_glyph,
   output logic                                 rsp_out_of_range,
   input  wire logic                            csr_wen,
   input  wire logic [bta_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bta_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bta_pkg::state_type                state_ff, state_in;

   logic [bta_pkg::SRC_CSR_W-1:0]     src_width_ff, src_height_ff;
   logic [bta_pkg::DST_CSR_W-1:0]     dst_width_ff, dst_height_ff;

   logic [bta_pkg::POS_W-1:0]         x_ff, y_ff;
   logic [bta_pkg::XW-1:0]            sx_ff;
   logic [bta_pkg::YW-1:0]            sy_ff;
   logic [bta_pkg::GLYPH_W-1:0]       glyph_ff;
   logic                              oor_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bta_pkg::GLYPH_W-1:0]       rsp_glyph_ff;
   logic                              rsp_oor_ff;

   logic [bta_pkg::SZ_W-1:0]          sw, sh;
   logic                              req_fire;
   logic                              is_render;
   logic                              render_oor;
   logic                              wr_in_range;
   logic                              wr_en;
   logic [bta_pkg::ADDR_W-1:0]        wr_addr;
   logic [bta_pkg::ADDR_W-1:0]        rd_addr;
   bta_pkg::pixel_type                wr_data;
   bta_pkg::pixel_type                rd_data;
   logic [bta_pkg::SUM_W-1:0]         chan_sum;

   // sequencer outputs
   logic                              mul_sel_y;
   logic                              rd_en;
   logic                              rsp_load;
   bta_pkg::div_ctl_type              div_ctl;
   bta_pkg::div_stat_type             div_stat;
   logic [bta_pkg::PROD_W-1:0]        mul_a, mul_b, product;
   logic [bta_pkg::DST_CSR_W-1:0]     divisor;
   logic [bta_pkg::QW-1:0]            quotient;

   // ---------------- size registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= bta_pkg::SRC_WIDTH_RST;
         src_height_ff <= bta_pkg::SRC_HEIGHT_RST;
         dst_width_ff  <= bta_pkg::DST_WIDTH_RST;
         dst_height_ff <= bta_pkg::DST_HEIGHT_RST;
      end else if (csr_wen) begin
         unique case (bta_pkg::csr_type'(csr_index))
            bta_pkg::CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[bta_pkg::SRC_CSR_W-1:0];
            bta_pkg::CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[bta_pkg::SRC_CSR_W-1:0];
            bta_pkg::CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            bta_pkg::CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sw = bta_pkg::clamp_size(src_width_ff, bta_pkg::SZ_W'(bta_pkg::MAX_SRC_WIDTH));
   assign sh = bta_pkg::clamp_size(src_height_ff, bta_pkg::SZ_W'(bta_pkg::MAX_SRC_HEIGHT));

   // ---------------- request decode ----------------
   assign req_fire   = req_valid && req_ready;
   assign is_render  = (req_opcode == bta_pkg::OP_RENDER);
   assign render_oor = (req_pos_x >= dst_width_ff) || (req_pos_y >= dst_height_ff);
   assign wr_in_range = (bta_pkg::PROD_W'(req_pos_x) < bta_pkg::PROD_W'(sw)) &&
                        (bta_pkg::PROD_W'(req_pos_y) < bta_pkg::PROD_W'(sh));
   assign wr_en   = req_fire && !is_render && wr_in_range;
   assign wr_addr = bta_pkg::ADDR_W'(bta_pkg::YW'(req_pos_y)) *
                    bta_pkg::ADDR_W'(bta_pkg::MAX_SRC_WIDTH) +
                    bta_pkg::ADDR_W'(bta_pkg::XW'(req_pos_x));
   assign wr_data = '{see_through: req_see_through, red: req_red,
                      green: req_green, blue: req_blue};
   assign rd_addr = bta_pkg::ADDR_W'(sy_ff) * bta_pkg::ADDR_W'(bta_pkg::MAX_SRC_WIDTH) +
                    bta_pkg::ADDR_W'(sx_ff);

   // ---------------- shared multiplier feeding the divider ----------------
   assign mul_a   = mul_sel_y ? bta_pkg::PROD_W'(y_ff) : bta_pkg::PROD_W'(x_ff);
   assign mul_b   = mul_sel_y ? bta_pkg::PROD_W'(sh) : bta_pkg::PROD_W'(sw);
   assign product = mul_a * mul_b;
   assign divisor = mul_sel_y ? dst_height_ff : dst_width_ff;

   bta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (product),
      .divisor  (divisor),
      .stat     (div_stat),
      .quotient (quotient)
   );

   bta_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign chan_sum = bta_pkg::SUM_W'(rd_data.red) + bta_pkg::SUM_W'(rd_data.green) +
                     bta_pkg::SUM_W'(rd_data.blue);

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bta_pkg::ST_IDLE: begin
            if (req_fire && is_render) begin
               state_in = render_oor ? bta_pkg::ST_DONE : bta_pkg::ST_LOAD_X;
            end
         end
         bta_pkg::ST_LOAD_X: state_in = bta_pkg::ST_DIV_X;
         bta_pkg::ST_DIV_X: begin
            if (div_stat.done) begin
               state_in = bta_pkg::ST_LOAD_Y;
            end
         end
         bta_pkg::ST_LOAD_Y: state_in = bta_pkg::ST_DIV_Y;
         bta_pkg::ST_DIV_Y: begin
            if (div_stat.done) begin
               state_in = bta_pkg::ST_READ;
            end
         end
         bta_pkg::ST_READ:  state_in = bta_pkg::ST_SHADE;
         bta_pkg::ST_SHADE: state_in = bta_pkg::ST_DONE;
         bta_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = bta_pkg::ST_IDLE;
            end
         end
         default: state_in = bta_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: outputs ----------------
   always_comb begin
      req_ready     = 1'b0;
      mul_sel_y     = 1'b0;
      div_ctl.start = 1'b0;
      rd_en         = 1'b0;
      rsp_load      = 1'b0;
      unique case (state_ff)
         bta_pkg::ST_IDLE:   req_ready = 1'b1;
         bta_pkg::ST_LOAD_X: div_ctl.start = 1'b1;
         bta_pkg::ST_DIV_X:  mul_sel_y = 1'b0;
         bta_pkg::ST_LOAD_Y: begin
            mul_sel_y     = 1'b1;
            div_ctl.start = 1'b1;
         end
         bta_pkg::ST_DIV_Y:  mul_sel_y = 1'b1;
         bta_pkg::ST_READ:   rd_en = 1'b1;
         bta_pkg::ST_SHADE:  rd_en = 1'b0;
         bta_pkg::ST_DONE:   rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bta_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- render datapath ----------------
   always_ff @(posedge clock) begin
      if (req_fire && is_render) begin
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         oor_ff   <= render_oor;
         glyph_ff <= bta_pkg::SPACE_CODE;
      end
      if (state_ff == bta_pkg::ST_DIV_X && div_stat.done) begin
         sx_ff <= bta_pkg::XW'(quotient);
      end
      if (state_ff == bta_pkg::ST_DIV_Y && div_stat.done) begin
         sy_ff <= bta_pkg::YW'(quotient);
      end
      if (state_ff == bta_pkg::ST_SHADE) begin
         glyph_ff <= rd_data.see_through ? bta_pkg::SPACE_CODE :
                     bta_pkg::shade_glyph(chan_sum);
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_glyph_ff <= glyph_ff;
         rsp_oor_ff   <= oor_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_glyph        = rsp_glyph_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // ---------------- assertions ----------------
   a_div_done_in_div_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == bta_pkg::ST_DIV_X || state_ff == bta_pkg::ST_DIV_Y))
      else $error("divider finished outside a division step");

   a_no_start_while_busy: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_stat.busy)
      else $error("divider restarted while still running");

   a_render_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_render) |=> !req_ready)
      else $error("request taken while a render is in flight");

   a_oor_gives_space: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_glyph == bta_pkg::SPACE_CODE))
      else $error("out-of-range response without a space glyph");

endmodule

`default_nettype wire
